// ===== design/itoa_pkg.sv =====
// Shared constants, types and state encoding for the decimal ASCII converter.
package itoa_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int BCD_DIGITS  = (VALUE_BITS * 3) / 10 + 1;
  localparam int BCD_W       = BCD_DIGITS * 4;
  localparam int ITER_W      = $clog2(VALUE_BITS);
  localparam int DCNT_W      = $clog2(BCD_DIGITS + 1);
  localparam int CHAR_W      = 8;
  localparam int COUNT_W     = 4;

  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [3:0]        ADD3_LIMIT = 4'd5;
  localparam logic [3:0]        ADD3       = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS
  } itoa_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } itoa_cmd_t;

  typedef struct packed {
    logic iter_done;
    logic top_zero;
    logic one_left;
    logic neg;
    logic out_free;
  } itoa_status_t;

endpackage

// ===== design/itoa_datapath.sv =====
// Datapath: magnitude, shift-add-3 BCD conversion, digit counters and output register.
module itoa_datapath
  import itoa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  itoa_cmd_t             cmd,
  output itoa_status_t          sts,
  input  logic                  op,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     ascii_char,
  output logic [COUNT_W-1:0]    char_count,
  output logic                  last
);

  logic [VALUE_BITS-1:0] bin;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic                  neg;
  logic [ITER_W-1:0]     iter;
  logic [DCNT_W-1:0]     digits_left;
  logic [COUNT_W-1:0]    char_cnt;
  logic                  is_neg;
  logic [3:0]            top_nib;

  assign is_neg  = !op && value[VALUE_BITS-1];
  assign top_nib = bcd[BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= ADD3_LIMIT) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + ADD3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_comb begin
    sts.iter_done = (iter == ITER_W'(VALUE_BITS - 1));
    sts.top_zero  = (top_nib == 4'd0);
    sts.one_left  = (digits_left == DCNT_W'(1));
    sts.neg       = neg;
    sts.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin         <= is_neg ? (~value + VALUE_BITS'(1)) : value;
      bcd         <= '0;
      neg         <= is_neg;
      iter        <= '0;
      digits_left <= DCNT_W'(BCD_DIGITS);
      char_cnt    <= '0;
    end else if (cmd.step) begin
      bcd  <= {bcd_adj[BCD_W-2:0], bin[VALUE_BITS-1]};
      bin  <= {bin[VALUE_BITS-2:0], 1'b0};
      iter <= iter + ITER_W'(1);
    end else if (cmd.skip || cmd.emit_digit) begin
      bcd         <= {bcd[BCD_W-5:0], 4'd0};
      digits_left <= digits_left - DCNT_W'(1);
    end
    if (cmd.emit_sign || cmd.emit_digit) begin
      char_cnt   <= char_cnt + COUNT_W'(1);
      char_count <= char_cnt + COUNT_W'(1);
      ascii_char <= cmd.emit_sign ? CH_MINUS : (CH_ZERO | {4'd0, top_nib});
      last       <= cmd.emit_digit && sts.one_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/itoa_ctrl.sv =====
// Controller: sequences load, conversion, leading-zero skip and character output.
module itoa_ctrl
  import itoa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  itoa_status_t sts,
  output itoa_cmd_t    cmd
);

  itoa_state_t state;
  itoa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (sts.iter_done) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        if (!sts.top_zero || sts.one_left) state_next = sts.neg ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        if (sts.out_free) state_next = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (sts.out_free && sts.one_left) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CONVERT: cmd.step = 1'b1;
      ST_SKIP:    cmd.skip = sts.top_zero && !sts.one_left;
      ST_SIGN:    cmd.emit_sign = sts.out_free;
      ST_DIGITS:  cmd.emit_digit = sts.out_free;
      default:    cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
    else $error("character written while output register still held");

  a_convert_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONVERT && !sts.iter_done) |=> state == ST_CONVERT)
    else $error("conversion left early");

  a_last_digit_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_digit && sts.one_left) |=> state == ST_IDLE)
    else $error("final digit did not end the item");

  a_sign_only_neg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN) |-> sts.neg)
    else $error("sign emitted for non-negative value");
`endif

endmodule

// ===== design/int_to_decimal_ascii_unit.sv =====
// Top level: binary to decimal ASCII converter, one character per output transfer.
// Converts one VALUE_BITS-wide value per input transfer (op 0 = signed, 1 = unsigned)
// into decimal ASCII, most significant digit first, '-' first for negative signed
// values, with a running char_count and last on the final character. One item is
// worked on at a time: after the input transfer the shift-add-3 converter shifts in
// all VALUE_BITS bits, a skip pass drops leading zeros, then characters leave one per
// cycle while the output is not stalled. The next input transfer is taken only after
// the last character is written; that final character may still wait in the output
// register while the next item is taken.
module int_to_decimal_ascii_unit
  import itoa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     ascii_char,
  output logic [COUNT_W-1:0]    char_count,
  output logic                  last
);

  itoa_cmd_t    cmd;
  itoa_status_t sts;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itoa_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .op         (op),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ascii_char (ascii_char),
    .char_count (char_count),
    .last       (last)
  );

endmodule
